@@ hdl/lbkc_pkg.sv @@
// Package with the types, constants and codes shared by the bitmap key cache.
package lbkc_pkg;

    localparam int CACHE_SLOTS = 32;
    localparam int IDX_W       = $clog2(CACHE_SLOTS);

    localparam int WIDTH_W = 16;
    localparam int HEIGHT_W = 16;
    localparam int BPP_W = 3;
    localparam int HASH_W = 64;

    typedef logic [IDX_W-1:0] slot_idx_t;
    typedef logic [IDX_W:0]   slot_cnt_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  bitmap_width;
        logic [HEIGHT_W-1:0] bitmap_height;
        logic [BPP_W-1:0]    pixel_bytes;
        logic [HASH_W-1:0]   content_hash;
    } key_t;

    typedef enum logic [1:0] {
        STATUS_NOT_CACHED = 2'd0,
        STATUS_CACHED     = 2'd1,
        STATUS_INSERTED   = 2'd2,
        STATUS_EVICTED    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_VREAD,
        ST_MISS,
        ST_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic set_nc;
        logic scan;
        logic hit_upd;
        logic vread;
        logic miss_upd;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic in_unsupported;
        logic match;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/lbkc_ifs.sv @@
// Valid/ready channel interfaces for key requests and cache results.
interface lbkc_key_if;
    logic                        valid;
    logic                        ready;
    logic [lbkc_pkg::WIDTH_W-1:0]  bitmap_width;
    logic [lbkc_pkg::HEIGHT_W-1:0] bitmap_height;
    logic [lbkc_pkg::BPP_W-1:0]    pixel_bytes;
    logic [lbkc_pkg::HASH_W-1:0]   content_hash;

    modport source (output valid, bitmap_width, bitmap_height, pixel_bytes, content_hash,
                    input ready);
    modport sink (input valid, bitmap_width, bitmap_height, pixel_bytes, content_hash,
                  output ready);
endinterface

interface lbkc_result_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [lbkc_pkg::WIDTH_W-1:0]  evicted_width;
    logic [lbkc_pkg::HEIGHT_W-1:0] evicted_height;
    logic [lbkc_pkg::BPP_W-1:0]    evicted_pixel_bytes;
    logic [lbkc_pkg::HASH_W-1:0]   evicted_hash;

    modport source (output valid, status, evicted_width, evicted_height,
                    evicted_pixel_bytes, evicted_hash, input ready);
    modport sink (input valid, status, evicted_width, evicted_height,
                  evicted_pixel_bytes, evicted_hash, output ready);
endinterface

@@ hdl/lru_bitmap_key_cache_core.sv @@
// Top level of the fully associative LRU cache of bitmap keys.
// Each key request is looked up by a scan of the key store, one slot per cycle through
// its single registered read port. A request is accepted, then scanned; a hit then
// updates the ranks, while a miss reads the victim, then writes the new key over it and
// updates the ranks; last the result is loaded. A hit ends the scan early, and a key
// with zero bytes per pixel skips the scan and the update. A new request is accepted
// once the previous one has reached the result register, even while that result waits
// to be taken. Valid bits and recency ranks are flip-flops that reset sets at once.
module lru_bitmap_key_cache_core (
    input  logic  clk,
    input  logic  rst_n,
    lbkc_key_if.sink      key,
    lbkc_result_if.source result
);
    import lbkc_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    key_t    in_key;
    key_t    out_evict;
    status_t out_status;
    logic    in_ready;
    logic    out_valid;

    assign in_key.bitmap_width  = key.bitmap_width;
    assign in_key.bitmap_height = key.bitmap_height;
    assign in_key.pixel_bytes   = key.pixel_bytes;
    assign in_key.content_hash  = key.content_hash;
    assign key.ready            = in_ready;

    lbkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    lbkc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_valid   (key.valid),
        .in_key     (in_key),
        .out_valid  (out_valid),
        .out_ready  (result.ready),
        .out_status (out_status),
        .out_evict  (out_evict)
    );

    assign result.valid               = out_valid;
    assign result.status              = out_status;
    assign result.evicted_width       = out_evict.bitmap_width;
    assign result.evicted_height      = out_evict.bitmap_height;
    assign result.evicted_pixel_bytes = out_evict.pixel_bytes;
    assign result.evicted_hash        = out_evict.content_hash;

endmodule

@@ hdl/lbkc_ctrl.sv @@
// Controller state machine that sequences lookup, update and result delivery.
module lbkc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  lbkc_pkg::sts_t sts,
    output lbkc_pkg::cmd_t cmd,
    output logic           in_ready
);
    import lbkc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_unsupported)
                    begin
                        cmd.set_nc = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match)
                begin
                    state_next = ST_HIT;
                end
                else if (sts.scan_done)
                begin
                    state_next = ST_VREAD;
                end
            end
            ST_HIT:
            begin
                cmd.hit_upd = 1'b1;
                state_next  = ST_OUT;
            end
            ST_VREAD:
            begin
                cmd.vread  = 1'b1;
                state_next = ST_MISS;
            end
            ST_MISS:
            begin
                cmd.miss_upd = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/lbkc_datapath.sv @@
// Datapath: key store, valid bits, recency ranks, scan pipeline and result register.
module lbkc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  lbkc_pkg::cmd_t    cmd,
    output lbkc_pkg::sts_t    sts,
    input  logic              in_valid,
    input  lbkc_pkg::key_t    in_key,
    output logic              out_valid,
    input  logic              out_ready,
    output lbkc_pkg::status_t out_status,
    output lbkc_pkg::key_t    out_evict
);
    import lbkc_pkg::*;

    key_t      mem [CACHE_SLOTS];
    key_t      mem_q_reg;
    slot_idx_t rd_addr;

    key_t      key_reg;
    slot_cnt_t issue_cnt_reg;
    logic      cmp_valid_reg;
    slot_idx_t cmp_addr_reg;
    slot_idx_t victim_reg;
    slot_idx_t hit_slot_reg;
    logic      valid_reg [CACHE_SLOTS];
    slot_idx_t rank_reg [CACHE_SLOTS];

    status_t   res_status_reg;
    key_t      res_evict_reg;
    logic      out_valid_reg;
    status_t   out_status_reg;
    key_t      out_evict_reg;

    slot_idx_t issue_idx;
    logic      issuing;
    logic      match;
    logic      upd_en;
    slot_idx_t upd_slot;
    slot_idx_t upd_rank;

    assign issue_idx = issue_cnt_reg[IDX_W-1:0];
    assign issuing   = (issue_cnt_reg < slot_cnt_t'(CACHE_SLOTS));
    assign rd_addr   = cmd.vread ? victim_reg : issue_idx;

    assign match = cmp_valid_reg && valid_reg[cmp_addr_reg] && (mem_q_reg == key_reg);

    assign upd_en   = cmd.hit_upd || cmd.miss_upd;
    assign upd_slot = cmd.hit_upd ? hit_slot_reg : victim_reg;
    assign upd_rank = rank_reg[upd_slot];

    assign sts.in_valid       = in_valid;
    assign sts.in_unsupported = (in_key.pixel_bytes == '0);
    assign sts.match          = match;
    assign sts.scan_done      = cmp_valid_reg && !match
                                && (cmp_addr_reg == slot_idx_t'(CACHE_SLOTS - 1));
    assign sts.out_free       = !out_valid_reg || out_ready;

    // Key store: one read port whose data is registered, one write port.
    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[rd_addr];
        if (cmd.miss_upd)
        begin
            mem[victim_reg] <= key_reg;
        end
    end

    // Scan pipeline: reads issue one slot per cycle and each is compared in the following cycle.
    // The least recent slot is found on the way, from the rank of each issued slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            issue_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (issuing)
            begin
                issue_cnt_reg <= issue_cnt_reg + slot_cnt_t'(1);
            end
            cmp_valid_reg <= issuing;
        end
        else
        begin
            cmp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= in_key;
        end
        if (cmd.scan && issuing)
        begin
            cmp_addr_reg <= issue_idx;
            if (rank_reg[issue_idx] == slot_idx_t'(CACHE_SLOTS - 1))
            begin
                victim_reg <= issue_idx;
            end
        end
        if (cmd.scan && match)
        begin
            hit_slot_reg <= cmp_addr_reg;
        end
        if (cmd.set_nc)
        begin
            res_status_reg <= STATUS_NOT_CACHED;
            res_evict_reg  <= '0;
        end
        else if (cmd.hit_upd)
        begin
            res_status_reg <= STATUS_CACHED;
            res_evict_reg  <= '0;
        end
        else if (cmd.miss_upd)
        begin
            if (valid_reg[victim_reg])
            begin
                res_status_reg <= STATUS_EVICTED;
                res_evict_reg  <= mem_q_reg;
            end
            else
            begin
                res_status_reg <= STATUS_INSERTED;
                res_evict_reg  <= '0;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_evict_reg  <= res_evict_reg;
        end
    end

    // Valid bits and recency ranks; rank 0 is the most recent slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= slot_idx_t'(i);
            end
        end
        else
        begin
            if (cmd.miss_upd)
            begin
                valid_reg[victim_reg] <= 1'b1;
            end
            if (upd_en)
            begin
                for (int i = 0; i < CACHE_SLOTS; i++)
                begin
                    if (slot_idx_t'(i) == upd_slot)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (rank_reg[i] < upd_rank)
                    begin
                        rank_reg[i] <= rank_reg[i] + slot_idx_t'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_evict  = out_evict_reg;

endmodule

@@ bench/lbkc_result_checker.sv @@
// Checker that predicts the cache answer for each key request and compares the results.
module lbkc_result_checker (
    input  logic          clk,
    input  logic          rst_n,
    lbkc_key_if           key,
    lbkc_result_if        result,
    output int            mismatches,
    output int            outstanding,
    output int            status_tally [4]
);
    import lbkc_pkg::*;

    typedef struct packed {
        status_t status;
        key_t    evicted;
    } answer_t;

    key_t        slot_key  [CACHE_SLOTS];
    logic        slot_used [CACHE_SLOTS];
    int unsigned slot_age  [CACHE_SLOTS];
    answer_t     answer_q  [$];

    // Slot s becomes the most recent; every slot that was more recent ages by one.
    function automatic void promote(int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (slot_age[i] < r)
            begin
                slot_age[i]++;
            end
        end
        slot_age[s] = 0;
    endfunction

    function automatic answer_t cache_lookup(key_t k);
        answer_t a;
        int      hit_slot;
        int      victim;
        a        = '0;
        hit_slot = -1;
        victim   = 0;
        if (k.pixel_bytes == '0)
        begin
            a.status = STATUS_NOT_CACHED;
            return a;
        end
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (hit_slot < 0 && slot_used[i] && slot_key[i] == k)
            begin
                hit_slot = i;
            end
        end
        if (hit_slot >= 0)
        begin
            promote(hit_slot);
            a.status = STATUS_CACHED;
            return a;
        end
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (slot_age[i] == CACHE_SLOTS - 1)
            begin
                victim = i;
            end
        end
        if (slot_used[victim])
        begin
            a.status  = STATUS_EVICTED;
            a.evicted = slot_key[victim];
        end
        else
        begin
            a.status = STATUS_INSERTED;
        end
        promote(victim);
        slot_key[victim]  = k;
        slot_used[victim] = 1'b1;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_t    k;
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                slot_key[i]  = '0;
                slot_used[i] = 1'b0;
                slot_age[i]  = i;
            end
            answer_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
            for (int i = 0; i < 4; i++)
            begin
                status_tally[i] <= 0;
            end
        end
        else
        begin
            if (key.valid && key.ready)
            begin
                k.bitmap_width  = key.bitmap_width;
                k.bitmap_height = key.bitmap_height;
                k.pixel_bytes   = key.pixel_bytes;
                k.content_hash  = key.content_hash;
                answer_q.push_back(cache_lookup(k));
            end
            if (result.valid && result.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: result with no request outstanding, status %0d",
                                 $realtime, result.status);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    status_tally[want.status] <= status_tally[want.status] + 1;
                    if (result.status !== want.status
                        || result.evicted_width !== want.evicted.bitmap_width
                        || result.evicted_height !== want.evicted.bitmap_height
                        || result.evicted_pixel_bytes !== want.evicted.pixel_bytes
                        || result.evicted_hash !== want.evicted.content_hash)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch: expected status %0d key %h/%h/%h/%h",
                                     $realtime, want.status, want.evicted.bitmap_width,
                                     want.evicted.bitmap_height, want.evicted.pixel_bytes,
                                     want.evicted.content_hash);
                            $display("%0t:           got status %0d key %h/%h/%h/%h",
                                     $realtime, result.status, result.evicted_width,
                                     result.evicted_height, result.evicted_pixel_bytes,
                                     result.evicted_hash);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= answer_q.size();
        end
    end

endmodule

@@ bench/lru_bitmap_key_cache_core_tb.sv @@
// Testbench top: clock, reset, key request stimulus, result stalls and the verdict.
module lru_bitmap_key_cache_core_tb;
    import lbkc_pkg::*;

    localparam int RANDOM_REQUESTS = 900;
    localparam int CALM_TAIL       = 120;
    localparam int DRAIN_CYCLES    = 2 * CACHE_SLOTS + 10;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int POOL_DEPTH      = 48;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic calm  = 1'b0;

    int   mismatches;
    int   outstanding;
    int   status_tally [4];
    int   sent_count  = 0;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    key_t recent_keys [$];

    lbkc_key_if    key_ch ();
    lbkc_result_if res_ch ();

    lru_bitmap_key_cache_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_ch),
        .result (res_ch)
    );

    lbkc_result_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (key_ch),
        .result       (res_ch),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .status_tally (status_tally)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: ready is dropped in random bursts of stalls, none in the tail.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 12)
        begin
            stall_left = $urandom_range(0, 8);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", outstanding);
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_key(input key_t k);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            repeat ($urandom_range(1, 9))
            begin
                @(negedge clk);
                key_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        key_ch.valid         <= 1'b1;
        key_ch.bitmap_width  <= k.bitmap_width;
        key_ch.bitmap_height <= k.bitmap_height;
        key_ch.pixel_bytes   <= k.pixel_bytes;
        key_ch.content_hash  <= k.content_hash;
        @(posedge clk);
        while (!key_ch.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    function automatic key_t make_key(logic [15:0] w, logic [15:0] h, logic [2:0] b,
                                      logic [63:0] hash);
        key_t k;
        k.bitmap_width  = w;
        k.bitmap_height = h;
        k.pixel_bytes   = b;
        k.content_hash  = hash;
        return k;
    endfunction

    function automatic logic [15:0] pick_dim();
        logic [15:0] d;
        case ($urandom_range(0, 9))
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            default: d = 16'($urandom);
        endcase
        return d;
    endfunction

    function automatic key_t fresh_key();
        return make_key(pick_dim(), pick_dim(), 3'($urandom_range(1, 7)),
                        {$urandom, $urandom});
    endfunction

    // A known key with one bit flipped in one field; it must not match the original.
    function automatic key_t near_miss(key_t k);
        key_t n;
        n = k;
        case ($urandom_range(0, 3))
            0: n.bitmap_width   ^= 16'(1) << $urandom_range(0, 15);
            1: n.bitmap_height  ^= 16'(1) << $urandom_range(0, 15);
            2: n.pixel_bytes    ^= 3'(1) << $urandom_range(0, 2);
            default: n.content_hash ^= 64'(1) << $urandom_range(0, 63);
        endcase
        return n;
    endfunction

    function automatic void remember(key_t k);
        if (k.pixel_bytes != '0)
        begin
            recent_keys.push_back(k);
            if (recent_keys.size() > POOL_DEPTH)
            begin
                void'(recent_keys.pop_front());
            end
        end
    endfunction

    initial
    begin
        key_t k;
        int   roll;
        key_ch.valid         = 1'b0;
        key_ch.bitmap_width  = '0;
        key_ch.bitmap_height = '0;
        key_ch.pixel_bytes   = '0;
        key_ch.content_hash  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: field extremes, unsupported format, hits and near misses.
        send_key(make_key(16'h0000, 16'h0000, 3'd1, 64'h0));
        send_key(make_key(16'hFFFF, 16'hFFFF, 3'd7, '1));
        send_key(make_key(16'h0000, 16'h0000, 3'd1, 64'h0));
        send_key(make_key(16'h0000, 16'h0000, 3'd0, 64'h0));
        send_key(make_key(16'hFFFF, 16'hFFFF, 3'd0, '1));
        send_key(make_key(16'h0000, 16'h0000, 3'd1, 64'h1));
        send_key(make_key(16'h0000, 16'h0000, 3'd2, 64'h0));
        send_key(make_key(16'h0001, 16'h0000, 3'd1, 64'h0));
        send_key(make_key(16'h0000, 16'h0001, 3'd1, 64'h0));
        send_key(make_key(16'h0000, 16'h0000, 3'd1, 64'h8000_0000_0000_0000));
        send_key(make_key(16'hFFFF, 16'hFFFF, 3'd7, '1));
        send_key(make_key(16'h1234, 16'h5678, 3'd4, 64'h0123_4567_89AB_CDEF));
        send_key(make_key(16'h1234, 16'h5678, 3'd5, 64'h0123_4567_89AB_CDEF));
        send_key(make_key(16'h1234, 16'h5678, 3'd6, 64'h0123_4567_89AB_CDEF));
        send_key(make_key(16'h1234, 16'h5678, 3'd3, 64'h0123_4567_89AB_CDEF));
        send_key(make_key(16'h1234, 16'h5678, 3'd4, 64'h0123_4567_89AB_CDEF));
        send_key(make_key(16'h0000, 16'h0001, 3'd1, 64'h0));
        send_key(make_key(16'h0000, 16'h0000, 3'd1, 64'h0));

        // Random requests: frequent reuse of recent keys so hits and evictions both occur.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n >= RANDOM_REQUESTS - CALM_TAIL)
            begin
                calm = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 45 && recent_keys.size() > 0)
            begin
                k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            end
            else if (roll < 80 || recent_keys.size() == 0)
            begin
                k = fresh_key();
                remember(k);
            end
            else if (roll < 90)
            begin
                k = fresh_key();
                k.pixel_bytes = '0;
            end
            else
            begin
                k = near_miss(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
                remember(k);
            end
            send_key(k);
        end
        @(negedge clk);
        key_ch.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d key requests: %0d hits, %0d inserts, %0d evictions,",
                 sent_count, status_tally[STATUS_CACHED], status_tally[STATUS_INSERTED],
                 status_tally[STATUS_EVICTED]);
        $display("%0d rejected for zero bytes per pixel; %0d mismatches.",
                 status_tally[STATUS_NOT_CACHED], mismatches);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
